FILE: rtl/pidsd_pkg.sv
// shared widths, codes, limits and helpers for the pid position loop
package pidsd_pkg;

  localparam int POS_W  = 10;
  localparam int TGT_W  = 8;
  localparam int GAIN_W = 16;
  localparam int WIN_W  = 8;
  localparam int SMS_W  = 12;
  localparam int FMS_W  = 8;
  localparam int ANG_W  = 6;
  localparam int DRV_W  = 5;
  localparam int MODE_W = 2;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 16;
  localparam int ERR_W  = 11;
  localparam int ISUM_W = 12;
  localparam int ELAP_W = 13;
  localparam int SUM_W  = 38;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } run_state_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TARGET   = 3'd0,
    CFG_GAIN_P   = 3'd1,
    CFG_GAIN_I   = 3'd2,
    CFG_GAIN_D   = 3'd3,
    CFG_WINDOW   = 3'd4,
    CFG_SETTLE   = 3'd5,
    CFG_FRAME_MS = 3'd6
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DONE = 2'd2;

  localparam logic [TGT_W-1:0]  TARGET_RST   = 8'd110;
  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd3768;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd1638;
  localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd1475;
  localparam logic [WIN_W-1:0]  WINDOW_RST   = 8'd13;
  localparam logic [SMS_W-1:0]  SETTLE_RST   = 12'd800;
  localparam logic [FMS_W-1:0]  FRAME_MS_RST = 8'd30;

  localparam logic signed [ISUM_W-1:0] ISUM_MAX   = 12'sd2000;
  localparam logic signed [ISUM_W:0]   ISUM_MAX_X = 13'sd2000;

  localparam logic [ANG_W-1:0]        SERVO_CENTER = 6'd30;
  localparam logic [ANG_W-1:0]        SERVO_REST   = 6'd10;
  localparam logic signed [DRV_W-1:0] DRIVE_MAX    = 5'sd15;

  // 15 * 20 * 16384, the drive limit in product scale
  localparam logic [SUM_W-1:0] NUM_LIMIT = 38'd4915200;
  // divide by 5 for values below 75: (x * 205) >> 10
  localparam logic [14:0] RECIP5 = 15'd205;

  typedef struct packed {
    logic                active;
    logic                settled;
    logic [MODE_W-1:0]   mode;
  } frame_ctl_t;

  function automatic logic [MODE_W-1:0] mode_code(run_state_t s);
    case (s)
      ST_RUN:  return MODE_RUN;
      ST_DONE: return MODE_DONE;
      default: return MODE_IDLE;
    endcase
  endfunction

endpackage

FILE: rtl/pid_position_loop_with_settle_detect_top.sv
// pid position loop with integral clamp and settle detection, pipelined top level
//
// usage: each input word is one control frame (position, start_req, stop).
// the loop state (mode, integral, last error, settle timer) is updated in the
// cycle the word is accepted, so consecutive words chain correctly at full rate.
// the drive then passes a product stage, a sum stage and a clamp/scale stage
// into the output register.
// throughput: one word per cycle without a stall, set by the state update loop.
// result words hold in the output register while out_ready is low; the stages
// behind it keep filling, and in_ready drops only once every stage is full.
// config port: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no word is in flight. unknown indexes are ignored.
// reset (rst, synchronous): registers go to their default values, mode idle,
// integral, last error and settle timer cleared, pipeline emptied.
// idle frames return rest angle 10, drive 0; integral, last error, timer hold.
module pid_position_loop_with_settle_detect_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pidsd_pkg::POS_W-1:0]         position,
  input  logic                                start_req,
  input  logic                                stop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pidsd_pkg::ANG_W-1:0]         servo_angle,
  output logic signed [pidsd_pkg::DRV_W-1:0]  drive,
  output logic                                settled,
  output logic [pidsd_pkg::MODE_W-1:0]        mode,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidsd_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [pidsd_pkg::CDAT_W-1:0]        cfg_data
);

  import pidsd_pkg::*;

  // configuration
  logic [TGT_W-1:0]  target;
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [WIN_W-1:0]  settle_window;
  logic [SMS_W-1:0]  settle_ms;
  logic [FMS_W-1:0]  frame_ms;

  // loop state
  run_state_t               run_mode;
  logic signed [ISUM_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]  last_error;
  logic [ELAP_W-1:0]        settle_elapsed;
  logic                     settle_running;

  // pipeline
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic signed [15:0]       s1_e20;
  logic signed [20:0]       s1_d400;
  logic signed [ISUM_W-1:0] s1_isum;
  frame_ctl_t               s1_ctl;
  logic signed [32:0]       s2_p;
  logic signed [28:0]       s2_i;
  logic signed [37:0]       s2_d;
  frame_ctl_t               s2_ctl;
  logic signed [SUM_W-1:0]  s3_sum;
  frame_ctl_t               s3_ctl;

  // frame update logic
  logic                     accept;
  run_state_t               mode_new;
  run_state_t               mode_fin;
  logic signed [ISUM_W-1:0] isum_base;
  logic signed [ISUM_W:0]   isum_acc;
  logic signed [ISUM_W-1:0] isum_next;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         err_mag;
  logic                     in_win;
  logic [ELAP_W-1:0]        elapsed_sum;
  logic [ELAP_W-1:0]        elapsed_next;
  logic                     running_next;
  logic                     settle_hit;
  logic                     active;
  logic signed [11:0]       diff;
  logic signed [20:0]       diff_x;
  logic signed [15:0]       err_x;

  // output scaling
  logic [SUM_W-1:0]         num_mag;
  logic [6:0]               num_hi;
  logic [14:0]              quot_prod;
  logic [3:0]               quot;
  logic signed [DRV_W-1:0]  drv;
  logic [ANG_W-1:0]         angle;

  assign cfg_ready = 1'b1;
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target        <= TARGET_RST;
      gain_p        <= GAIN_P_RST;
      gain_i        <= GAIN_I_RST;
      gain_d        <= GAIN_D_RST;
      settle_window <= WINDOW_RST;
      settle_ms     <= SETTLE_RST;
      frame_ms      <= FRAME_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TARGET:   target        <= cfg_data[TGT_W-1:0];
        CFG_GAIN_P:   gain_p        <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:   gain_i        <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:   gain_d        <= cfg_data[GAIN_W-1:0];
        CFG_WINDOW:   settle_window <= cfg_data[WIN_W-1:0];
        CFG_SETTLE:   settle_ms     <= cfg_data[SMS_W-1:0];
        CFG_FRAME_MS: frame_ms      <= cfg_data[FMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    isum_base = integral_sum;
    case (run_mode)
      ST_RUN:  mode_new = ST_RUN;
      ST_DONE: mode_new = stop ? ST_IDLE : ST_DONE;
      default: begin
        mode_new = start_req ? ST_RUN : ST_IDLE;
        if (start_req) isum_base = '0;
      end
    endcase
    active = (mode_new != ST_IDLE);

    err     = $signed({3'b000, target}) - $signed({1'b0, position});
    err_mag = err[ERR_W-1] ? 11'(-err) : err;
    in_win  = err_mag < {3'b000, settle_window};

    // settle timer
    elapsed_sum  = settle_elapsed + {5'b00000, frame_ms};
    elapsed_next = settle_elapsed;
    running_next = settle_running;
    settle_hit   = 1'b0;
    if (mode_new == ST_RUN) begin
      if (in_win) begin
        if (!settle_running) begin
          running_next = 1'b1;
          elapsed_next = '0;
        end else if (elapsed_sum >= {1'b0, settle_ms}) begin
          running_next = 1'b0;
          elapsed_next = '0;
          settle_hit   = 1'b1;
        end else begin
          elapsed_next = elapsed_sum;
        end
      end else begin
        running_next = 1'b0;
        elapsed_next = '0;
      end
    end
    mode_fin = settle_hit ? ST_DONE : mode_new;

    // integral with clamp
    isum_acc = {isum_base[ISUM_W-1], isum_base} + {{2{err[ERR_W-1]}}, err};
    if (isum_acc > ISUM_MAX_X) begin
      isum_next = ISUM_MAX;
    end else if (isum_acc < -ISUM_MAX_X) begin
      isum_next = -ISUM_MAX;
    end else begin
      isum_next = isum_acc[ISUM_W-1:0];
    end

    // difference and sign extensions for error * 20 and difference * 400 (stage 1)
    diff   = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
    diff_x = {{9{diff[11]}}, diff};
    err_x  = {{5{err[ERR_W-1]}}, err};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= ST_IDLE;
      integral_sum   <= '0;
      last_error     <= '0;
      settle_elapsed <= '0;
      settle_running <= 1'b0;
    end else if (accept) begin
      run_mode       <= mode_fin;
      settle_elapsed <= elapsed_next;
      settle_running <= running_next;
      if (active) begin
        integral_sum <= isum_next;
        last_error   <= err;
      end
    end
  end

  // stage 1: scaled terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && accept) begin
      s1_e20         <= (err_x <<< 4) + (err_x <<< 2);
      s1_d400        <= (diff_x <<< 8) + (diff_x <<< 7) + (diff_x <<< 4);
      s1_isum        <= isum_next;
      s1_ctl.active  <= active;
      s1_ctl.settled <= settle_hit;
      s1_ctl.mode    <= mode_code(mode_fin);
    end
  end

  // stage 2: gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_p   <= 33'($signed({1'b0, gain_p})) * 33'(s1_e20);
      s2_i   <= 29'($signed({1'b0, gain_i})) * 29'(s1_isum);
      s2_d   <= 38'($signed({1'b0, gain_d})) * 38'(s1_d400);
      s2_ctl <= s1_ctl;
    end
  end

  // stage 3: sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_sum <= {{5{s2_p[32]}}, s2_p} + {{9{s2_i[28]}}, s2_i} + s2_d;
      s3_ctl <= s2_ctl;
    end
  end

  // stage 4: clamp, truncate toward zero, servo angle
  always_comb begin
    num_mag   = s3_sum[SUM_W-1] ? SUM_W'(-s3_sum) : s3_sum;
    num_hi    = num_mag[22:16];
    quot_prod = {8'b0, num_hi} * RECIP5;
    quot      = quot_prod[13:10];
    if (num_mag >= NUM_LIMIT) begin
      drv = s3_sum[SUM_W-1] ? -DRIVE_MAX : DRIVE_MAX;
    end else begin
      drv = s3_sum[SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end
    if (!s3_ctl.active) drv = '0;
    angle = s3_ctl.active ? ({drv[DRV_W-1], drv} + SERVO_CENTER) : SERVO_REST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      servo_angle <= angle;
      drive       <= drv;
      settled     <= s3_ctl.settled;
      mode        <= s3_ctl.mode;
    end
  end

  a_settled_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && settled |-> mode == MODE_DONE)
    else $error("settled word without done mode");

  a_idle_rest: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_IDLE |-> servo_angle == SERVO_REST && drive == '0)
    else $error("idle word not at rest angle");

  a_angle_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode != MODE_IDLE |-> servo_angle == ({drive[DRV_W-1], drive} + SERVO_CENTER))
    else $error("servo angle does not follow drive");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    integral_sum <= ISUM_MAX && integral_sum >= -ISUM_MAX)
    else $error("integral out of clamp range");

  a_settle_stop: assert property (@(posedge clk) disable iff (rst)
    accept && settle_hit |=> !settle_running && run_mode == ST_DONE)
    else $error("settle did not stop timer and enter done");

endmodule
